@@ rtl/bvm_pkg.sv @@
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and constants for the battery voltage monitor: configuration
// register map, reset values and fixed voltage breakpoints.
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int MV_W       = 14;
    localparam int STEP_W     = 10;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [MV_W-1:0]  MV_ZERO_PCT   = 14'd3300;
    localparam logic [MV_W-1:0]  MV_FULL_PCT   = 14'd4200;
    localparam logic [MV_W-1:0]  MV_ENTRY_CHG  = 14'd4150;
    localparam logic [MV_W-1:0]  MV_PREV_VALID = 14'd100;
    localparam logic [MV_W-1:0]  MV_MAX_FIELD  = 14'd16383;
    localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;

    // floor(x / 9) for x below 1024 as (x * DIV9_M) >> DIV9_K
    localparam int               DIV9_K = 14;
    localparam logic [10:0]      DIV9_M = 11'd1821;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTER     = 3'd0,
        CFG_DROP      = 3'd1,
        CFG_MAX       = 3'd2,
        CFG_STEP      = 3'd3,
        CFG_CHG_HIGH  = 3'd4,
        CFG_CHG_LOW   = 3'd5,
        CFG_LOW_PCT   = 3'd6,
        CFG_CRIT_PCT  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [MV_W-1:0]   enter_mv;
        logic [MV_W-1:0]   drop_mv;
        logic [MV_W-1:0]   max_mv;
        logic [STEP_W-1:0] step_mv;
        logic [MV_W-1:0]   charge_high_mv;
        logic [MV_W-1:0]   charge_low_mv;
        logic [PCT_W-1:0]  low_percent;
        logic [PCT_W-1:0]  critical_percent;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        enter_mv:         14'd3000,
        drop_mv:          14'd2800,
        max_mv:           14'd4800,
        step_mv:          10'd35,
        charge_high_mv:   14'd4160,
        charge_low_mv:    14'd3400,
        low_percent:      7'd20,
        critical_percent: 7'd10
    };

endpackage

@@ rtl/battery_voltage_monitor.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// Pipeline: input register, battery state update with the divide-by-five
// multiply, result register with the percent multiply. Accepts one request per
// cycle while the output is not stalled; the state recurrence closes within the
// state update stage. Reset is synchronous and active low: it clears the battery
// state and pipeline valids and restores the configuration registers.
// ----------------------------------------------------------------------------
module battery_voltage_monitor #(
    parameter int FRAC_BITS = bvm_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bvm_pkg::MV_W-1:0]         i_sample_mv,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_present,
    output logic [bvm_pkg::PCT_W-1:0]        o_level_percent,
    output logic [bvm_pkg::MV_W-1:0]         o_filtered_mv,
    output logic                             o_charging,
    output logic                             o_low_flag,
    output logic                             o_critical_flag
);

    localparam int FW = bvm_pkg::MV_W + FRAC_BITS;
    localparam logic [FW:0] HALF_Q = (FW+1)'(1) << (FRAC_BITS - 1);

    bvm_pkg::t_cfg r_cfg, n_cfg;

    logic                      r_a_valid, n_a_valid;
    logic [bvm_pkg::MV_W-1:0]  r_a_sample;
    logic                      r_b_valid, n_b_valid;
    logic                      r_out_valid, n_out_valid;

    logic                      r_present, r_charging, r_low, r_crit;
    logic [bvm_pkg::PCT_W-1:0] r_percent;
    logic [bvm_pkg::MV_W-1:0]  r_filt_mv;

    logic                      c_ready, b_ready, a_ready;
    logic                      in_acc, a_move, b_move;

    logic                      st_present, st_charging;
    logic [FW-1:0]             st_filt;
    logic [bvm_pkg::PCT_W-1:0] percent;
    logic [FW:0]               filt_round;
    logic [bvm_pkg::MV_W:0]    filt_mv_wide;
    logic [bvm_pkg::MV_W-1:0]  filt_mv;

    // handshake chain
    always_comb begin
        c_ready = !r_out_valid || !i_out_stall;
        b_move  = r_b_valid && c_ready;
        b_ready = !r_b_valid || c_ready;
        a_move  = r_a_valid && b_ready;
        a_ready = !r_a_valid || b_ready;
        in_acc  = i_in_valid && a_ready;

        n_a_valid   = in_acc || (r_a_valid && !a_move);
        n_b_valid   = a_move || (r_b_valid && !b_move);
        n_out_valid = b_move || (r_out_valid && i_out_stall);
    end

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (bvm_pkg::t_cfg_idx'(i_cfg_idx))
                bvm_pkg::CFG_ENTER:    n_cfg.enter_mv         = i_cfg_data;
                bvm_pkg::CFG_DROP:     n_cfg.drop_mv          = i_cfg_data;
                bvm_pkg::CFG_MAX:      n_cfg.max_mv           = i_cfg_data;
                bvm_pkg::CFG_STEP:     n_cfg.step_mv          = i_cfg_data[bvm_pkg::STEP_W-1:0];
                bvm_pkg::CFG_CHG_HIGH: n_cfg.charge_high_mv   = i_cfg_data;
                bvm_pkg::CFG_CHG_LOW:  n_cfg.charge_low_mv    = i_cfg_data;
                bvm_pkg::CFG_LOW_PCT:  n_cfg.low_percent      = i_cfg_data[bvm_pkg::PCT_W-1:0];
                bvm_pkg::CFG_CRIT_PCT: n_cfg.critical_percent = i_cfg_data[bvm_pkg::PCT_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= bvm_pkg::CFG_RESET;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_a_valid   <= n_a_valid;
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_sample <= i_sample_mv;
        end
    end

    bvm_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (a_move),
        .i_sample_mv (r_a_sample),
        .i_cfg       (r_cfg),
        .o_present   (st_present),
        .o_filt      (st_filt),
        .o_charging  (st_charging)
    );

    bvm_level #(
        .FRAC_BITS (FRAC_BITS)
    ) u_level (
        .i_filt    (st_filt),
        .o_percent (percent)
    );

    // filtered value rounded half up, saturated to the field
    always_comb begin
        filt_round   = {1'b0, st_filt} + HALF_Q;
        filt_mv_wide = filt_round[FRAC_BITS +: bvm_pkg::MV_W+1];
        filt_mv      = filt_mv_wide[bvm_pkg::MV_W] ? bvm_pkg::MV_MAX_FIELD
                                                   : filt_mv_wide[bvm_pkg::MV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_present  <= st_present;
            r_charging <= st_charging;
            r_percent  <= percent;
            r_filt_mv  <= filt_mv;
            r_low      <= st_present && (percent < r_cfg.low_percent);
            r_crit     <= st_present && (percent < r_cfg.critical_percent);
        end
    end

    assign o_in_stall      = !a_ready;
    assign o_out_valid     = r_out_valid;
    assign o_present       = r_present;
    assign o_level_percent = r_percent;
    assign o_filtered_mv   = r_filt_mv;
    assign o_charging      = r_charging;
    assign o_low_flag      = r_low;
    assign o_critical_flag = r_crit;

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_present |-> (o_level_percent == '0) && (o_filtered_mv == '0)
            && !o_low_flag && !o_critical_flag)
        else $error("absent result with nonzero level or flags");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_level_percent <= bvm_pkg::PCT_FULL)
        else $error("level above full scale");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid && r_b_valid && r_out_valid)
        else $error("input stalled with a free pipeline stage");

endmodule

@@ rtl/bvm_core.sv @@
// ----------------------------------------------------------------------------
// bvm_core
// Battery state update: presence hysteresis, 0.8/0.2 moving average and
// charging detection, one sample per load.
// ----------------------------------------------------------------------------
module bvm_core #(
    parameter int FRAC_BITS = bvm_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [bvm_pkg::MV_W-1:0]            i_sample_mv,
    input  bvm_pkg::t_cfg                       i_cfg,
    output logic                                o_present,
    output logic [bvm_pkg::MV_W+FRAC_BITS-1:0]  o_filt,
    output logic                                o_charging
);

    localparam int FW    = bvm_pkg::MV_W + FRAC_BITS;
    localparam int SW    = FW + 3;
    localparam int DIV_K = SW + 2;
    localparam logic [SW-1:0] DIV5_M = SW'(((64'd1 << DIV_K) + 64'd4) / 64'd5);

    logic                     r_present, n_present;
    logic [FW-1:0]            r_filt, n_filt;
    logic                     r_charging, n_charging;
    logic [bvm_pkg::MV_W-1:0] r_prev, n_prev;

    logic [bvm_pkg::MV_W-1:0] floor_mv;
    logic                     in_range;
    logic [FW-1:0]            sample_q;
    logic [SW-1:0]            avg_sum;
    logic [2*SW-1:0]          avg_prod;
    logic [FW-1:0]            avg_q;
    logic [bvm_pkg::MV_W-1:0] rise, fall;
    logic [bvm_pkg::MV_W-1:0] step_ext;
    logic                     chg_step;

    always_comb begin
        floor_mv = r_present ? i_cfg.drop_mv : i_cfg.enter_mv;
        in_range = (i_sample_mv >= floor_mv) && (i_sample_mv <= i_cfg.max_mv);
        sample_q = FW'(i_sample_mv) << FRAC_BITS;
        // divide by five through the reciprocal
        avg_sum  = {1'b0, r_filt, 2'b00} + SW'(sample_q) + SW'(2);
        avg_prod = (2*SW)'(avg_sum) * (2*SW)'(DIV5_M);
        avg_q    = avg_prod[DIV_K +: FW];
        rise     = i_sample_mv - r_prev;
        fall     = r_prev - i_sample_mv;
        step_ext = bvm_pkg::MV_W'(i_cfg.step_mv);
    end

    always_comb begin
        n_present  = r_present;
        n_filt     = r_filt;
        n_charging = r_charging;
        n_prev     = r_prev;
        chg_step   = r_charging;
        if (i_load) begin
            if (in_range) begin
                n_prev = i_sample_mv;
                if (!r_present) begin
                    n_present  = 1'b1;
                    n_filt     = sample_q;
                    n_charging = i_sample_mv > bvm_pkg::MV_ENTRY_CHG;
                end else begin
                    n_filt = avg_q;
                    if (r_prev > bvm_pkg::MV_PREV_VALID) begin
                        if (i_sample_mv > r_prev && rise > step_ext) begin
                            chg_step = 1'b1;
                        end else if (r_prev > i_sample_mv && fall > step_ext) begin
                            chg_step = 1'b0;
                        end
                    end
                    if (i_sample_mv > i_cfg.charge_high_mv) begin
                        n_charging = 1'b1;
                    end else if (i_sample_mv < i_cfg.charge_low_mv) begin
                        n_charging = 1'b0;
                    end else begin
                        n_charging = chg_step;
                    end
                end
            end else if (r_present) begin
                n_present  = 1'b0;
                n_filt     = '0;
                n_charging = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= 1'b0;
            r_filt     <= '0;
            r_charging <= 1'b0;
            r_prev     <= '0;
        end else begin
            r_present  <= n_present;
            r_filt     <= n_filt;
            r_charging <= n_charging;
            r_prev     <= n_prev;
        end
    end

    assign o_present  = r_present;
    assign o_filt     = r_filt;
    assign o_charging = r_charging;

    a_absent_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_present |-> (r_filt == '0) && !r_charging)
        else $error("absent battery with filter or charging state left");

    a_filt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filt <= (FW'(bvm_pkg::MV_MAX_FIELD) << FRAC_BITS))
        else $error("filtered value above the largest sample");

endmodule

@@ rtl/bvm_level.sv @@
// ----------------------------------------------------------------------------
// bvm_level
// Linear map of the filtered voltage to a rounded 0-100 percent charge level.
// ----------------------------------------------------------------------------
module bvm_level #(
    parameter int FRAC_BITS = bvm_pkg::FRAC_BITS_DEF
) (
    input  logic [bvm_pkg::MV_W+FRAC_BITS-1:0] i_filt,
    output logic [bvm_pkg::PCT_W-1:0]          o_percent
);

    localparam int FW = bvm_pkg::MV_W + FRAC_BITS;
    localparam logic [FW-1:0] LO_Q    = FW'(bvm_pkg::MV_ZERO_PCT) << FRAC_BITS;
    localparam logic [FW-1:0] HI_Q    = FW'(bvm_pkg::MV_FULL_PCT) << FRAC_BITS;
    localparam logic [FW:0]   ROUND_Q = (FW+1)'(9) << (FRAC_BITS - 1);

    logic [FW-1:0] delta;
    logic [FW:0]   num;
    logic [9:0]    coarse;
    logic [20:0]   prod;

    // percent = (d*100 + span/2) / span with span = 900 mV, i.e. (d + 4.5 mV) / 9 mV
    always_comb begin
        delta  = i_filt - LO_Q;
        num    = {1'b0, delta} + ROUND_Q;
        coarse = num[FRAC_BITS +: 10];
        prod   = 21'(coarse) * 21'(bvm_pkg::DIV9_M);
        if (i_filt <= LO_Q) begin
            o_percent = '0;
        end else if (i_filt >= HI_Q) begin
            o_percent = bvm_pkg::PCT_FULL;
        end else begin
            o_percent = prod[bvm_pkg::DIV9_K +: bvm_pkg::PCT_W];
        end
    end

endmodule
